FILE: rtl/bba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants of the buddy block allocator: default geometry and
// request codes.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int POOL_ADDR_BITS_DEF = 18;
	localparam int TOP_ORDER_DEF      = 18;
	localparam int MIN_ORDER_DEF      = 6;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_ADD   = 2'd2;

endpackage
`default_nettype wire

FILE: rtl/bba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/buddy_block_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Buddy allocator with per-order LIFO free lists linked through a RAM.
// ----------------------------------------------------------------------------
// One request is worked at a time. After the result is placed in the output
// register the block returns to idle, where it takes the next item. If
// the previous result is still waiting, the new result is held until the
// output register is free. The free-list links live in a single RAM with one
// entry per minimum-order unit (64 bytes by default), with registered read
// data, so the cost of each request follows the number of RAM accesses it
// needs. Allocate splits a block of the lowest fitting non-empty order level
// by level, then pops one of the needed order; free pushes the block, searches
// the list of its order for the buddy and merges while it is found; add-region
// carves out aligned blocks one by one. A rejected request or an unknown
// request type goes straight to the result. No clearing pass is needed after reset.
module buddy_block_allocator_unit #(
	parameter int POOL_ADDR_BITS = bba_pkg::POOL_ADDR_BITS_DEF,
	parameter int TOP_ORDER      = bba_pkg::TOP_ORDER_DEF,
	parameter int MIN_ORDER      = bba_pkg::MIN_ORDER_DEF,
	localparam int IN_W  = ((3 * POOL_ADDR_BITS + 2 + 7) / 8) * 8,
	localparam int OUT_W = ((3 * POOL_ADDR_BITS + 3 + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// block_address, region_end, request_bytes
	input  wire logic [IN_W-1:0]  s_tdata,
	// req_type
	input  wire logic [1:0]       s_tuser,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// status, granted_address, allocated_bytes, total_bytes
	output logic      [OUT_W-1:0] m_tdata
);

	localparam int UW   = POOL_ADDR_BITS - MIN_ORDER;
	localparam int CW   = POOL_ADDR_BITS + 1;
	localparam int NORD = TOP_ORDER - MIN_ORDER + 1;
	localparam int NUNITS = 1 << UW;
	localparam int KW   = (NORD > 1) ? $clog2(NORD) : 1;
	localparam int OW   = $clog2(POOL_ADDR_BITS + TOP_ORDER + 2);
	localparam int PADW = OUT_W - (3 * POOL_ADDR_BITS + 3);

	localparam logic [OW-1:0] MIN_O = OW'(MIN_ORDER);
	localparam logic [OW-1:0] TOP_O = OW'(TOP_ORDER);
	localparam logic [CW-1:0] POOL_BYTES = {1'b1, {POOL_ADDR_BITS{1'b0}}};
	localparam logic [CW-1:0] UNIT_RND   = CW'((1 << MIN_ORDER) - 1);

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_DISP      = 5'd1;
	localparam logic [4:0] S_SPLIT_RD  = 5'd2;
	localparam logic [4:0] S_SPLIT_POP = 5'd3;
	localparam logic [4:0] S_SPLIT_HI  = 5'd4;
	localparam logic [4:0] S_SPLIT_LO  = 5'd5;
	localparam logic [4:0] S_POP_RD    = 5'd6;
	localparam logic [4:0] S_POP_WB    = 5'd7;
	localparam logic [4:0] S_MERGE_CHK = 5'd8;
	localparam logic [4:0] S_SRCH_RD   = 5'd9;
	localparam logic [4:0] S_SRCH_EV   = 5'd10;
	localparam logic [4:0] S_UNLINK    = 5'd11;
	localparam logic [4:0] S_MPOP_RD   = 5'd12;
	localparam logic [4:0] S_MPOP_WB   = 5'd13;
	localparam logic [4:0] S_MPUSH     = 5'd14;
	localparam logic [4:0] S_FREE_END  = 5'd15;
	localparam logic [4:0] S_ADD_CALC  = 5'd16;
	localparam logic [4:0] S_ADD_PUSH  = 5'd17;
	localparam logic [4:0] S_FIN       = 5'd18;

	logic [4:0]                state_q;
	logic [1:0]                req_q;
	logic [POOL_ADDR_BITS-1:0] addr_q;
	logic [CW-1:0]             end_q, rb_q, s_q, e_q;
	logic [OW-1:0]             ord_q, j_q, co_q, add_ord_q;
	logic [UW-1:0]             b_q, cur_q, bud_q, p_q;
	logic [UW:0]               steps_q;
	logic [UW-1:0]             head_q [NORD];
	logic [NORD-1:0]           hvalid_q;
	logic [CW-1:0]             alloc_q, total_q;
	logic                      res_status_q;
	logic [POOL_ADDR_BITS-1:0] res_addr_q;
	logic                      m_valid_q;
	logic                      out_status_q;
	logic [POOL_ADDR_BITS-1:0] out_addr_q;
	logic [CW-1:0]             out_alloc_q, out_total_q;

	logic          ram_we, ram_re;
	logic [UW-1:0] ram_waddr, ram_raddr;
	logic [UW:0]   ram_wdata, ram_rdata;
	logic          rd_valid;
	logic [UW-1:0] rd_next;

	logic          push_en, pop_en;
	logic [KW-1:0] push_k, pop_k;
	logic [UW-1:0] push_unit;

	logic [OW-1:0] size_ord, alloc_ord, add_ord;
	logic          alloc_hit;
	logic [CW-1:0] s_round, e_clip;
	logic [UW-1:0] half, bud_calc;

	function automatic logic [KW-1:0] ord_k(input logic [OW-1:0] o);
		return KW'(o - MIN_O);
	endfunction

	assign rd_valid = ram_rdata[UW];
	assign rd_next  = ram_rdata[UW-1:0];

	bba_ram #(
		.WIDTH (UW + 1),
		.DEPTH (NUNITS)
	) u_links (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// request size to order, at least the minimum order
	always_comb begin
		logic [CW-1:0] v;
		logic [OW-1:0] c;
		v = rb_q - CW'(1);
		c = '0;
		for (int i = 0; i < CW; i++) begin
			if (v[i]) c = OW'(i + 1);
		end
		if (rb_q <= CW'(1)) c = '0;
		size_ord = (c < MIN_O) ? MIN_O : c;
	end

	// lowest non-empty order that fits
	always_comb begin
		alloc_hit = 1'b0;
		alloc_ord = '0;
		for (int k = NORD - 1; k >= 0; k--) begin
			if (hvalid_q[k] && (OW'(k + MIN_ORDER) >= size_ord)) begin
				alloc_hit = 1'b1;
				alloc_ord = OW'(k + MIN_ORDER);
			end
		end
	end

	// region carving: largest aligned block that fits at s_q
	always_comb begin
		logic [CW-1:0] rem;
		logic [OW-1:0] tz, hb, o;
		rem = e_q - s_q;
		tz = TOP_O;
		for (int i = CW - 1; i >= 0; i--) begin
			if (s_q[i]) tz = OW'(i);
		end
		hb = '0;
		for (int i = 0; i < CW; i++) begin
			if (rem[i]) hb = OW'(i);
		end
		o = (tz < hb) ? tz : hb;
		add_ord = (o > TOP_O) ? TOP_O : o;
	end

	always_comb begin
		logic [CW-1:0] ec;
		s_round = (({1'b0, addr_q} + UNIT_RND) >> MIN_ORDER) << MIN_ORDER;
		ec      = (end_q > POOL_BYTES) ? POOL_BYTES : end_q;
		e_clip  = (ec >> MIN_ORDER) << MIN_ORDER;
	end

	assign half     = {{(UW-1){1'b0}}, 1'b1} << (j_q - MIN_O - OW'(1));
	assign bud_calc = cur_q ^ ({{(UW-1){1'b0}}, 1'b1} << (co_q - MIN_O));

	// list operations per state
	always_comb begin
		push_en   = 1'b0;
		push_k    = '0;
		push_unit = '0;
		pop_en    = 1'b0;
		pop_k     = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		unique case (state_q)
			S_DISP: begin
				if (req_q == bba_pkg::REQ_FREE && size_ord <= TOP_O) begin
					push_en   = 1'b1;
					push_k    = ord_k(size_ord);
					push_unit = addr_q[POOL_ADDR_BITS-1:MIN_ORDER];
				end
			end
			S_SPLIT_RD: begin
				ram_re    = 1'b1;
				ram_raddr = head_q[ord_k(j_q)];
			end
			S_SPLIT_POP: begin
				pop_en = 1'b1;
				pop_k  = ord_k(j_q);
			end
			S_SPLIT_HI: begin
				push_en   = 1'b1;
				push_k    = ord_k(j_q - OW'(1));
				push_unit = b_q + half;
			end
			S_SPLIT_LO: begin
				push_en   = 1'b1;
				push_k    = ord_k(j_q - OW'(1));
				push_unit = b_q;
			end
			S_POP_RD: begin
				ram_re    = 1'b1;
				ram_raddr = head_q[ord_k(ord_q)];
			end
			S_POP_WB: begin
				pop_en = 1'b1;
				pop_k  = ord_k(ord_q);
			end
			S_SRCH_RD: begin
				ram_re    = !steps_q[UW];
				ram_raddr = p_q;
			end
			S_SRCH_EV: begin
				ram_re    = rd_valid && (rd_next == bud_q);
				ram_raddr = bud_q;
			end
			S_UNLINK: begin
				ram_we    = 1'b1;
				ram_waddr = p_q;
				ram_wdata = ram_rdata;
			end
			S_MPOP_RD: begin
				ram_re    = 1'b1;
				ram_raddr = head_q[ord_k(co_q)];
			end
			S_MPOP_WB: begin
				pop_en = 1'b1;
				pop_k  = ord_k(co_q);
			end
			S_MPUSH: begin
				push_en   = 1'b1;
				push_k    = ord_k(co_q);
				push_unit = cur_q;
			end
			S_ADD_PUSH: begin
				push_en   = 1'b1;
				push_k    = ord_k(add_ord_q);
				push_unit = s_q[POOL_ADDR_BITS-1:MIN_ORDER];
			end
			default: begin
			end
		endcase
		if (push_en) begin
			ram_we    = 1'b1;
			ram_waddr = push_unit;
			ram_wdata = {hvalid_q[push_k], head_q[push_k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= '0;
			for (int k = 0; k < NORD; k++) begin
				head_q[k] <= '0;
			end
		end else if (push_en) begin
			head_q[push_k]   <= push_unit;
			hvalid_q[push_k] <= 1'b1;
		end else if (pop_en) begin
			head_q[pop_k]   <= rd_next;
			hvalid_q[pop_k] <= rd_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			alloc_q   <= '0;
			total_q   <= '0;
		end else begin
			if (m_valid_q && m_tready && state_q != S_FIN) m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						req_q   <= s_tuser;
						addr_q  <= s_tdata[POOL_ADDR_BITS-1:0];
						end_q   <= s_tdata[POOL_ADDR_BITS+CW-1:POOL_ADDR_BITS];
						rb_q    <= s_tdata[POOL_ADDR_BITS+2*CW-1:POOL_ADDR_BITS+CW];
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					res_addr_q   <= '0;
					res_status_q <= 1'b0;
					ord_q        <= size_ord;
					unique case (req_q)
						bba_pkg::REQ_ALLOC: begin
							if (size_ord > TOP_O || !alloc_hit) begin
								res_status_q <= 1'b1;
								state_q      <= S_FIN;
							end else begin
								j_q     <= alloc_ord;
								state_q <= (alloc_ord == size_ord) ? S_POP_RD : S_SPLIT_RD;
							end
						end
						bba_pkg::REQ_FREE: begin
							if (size_ord > TOP_O) begin
								res_status_q <= 1'b1;
								state_q      <= S_FIN;
							end else begin
								cur_q   <= addr_q[POOL_ADDR_BITS-1:MIN_ORDER];
								co_q    <= size_ord;
								state_q <= S_MERGE_CHK;
							end
						end
						bba_pkg::REQ_ADD: begin
							s_q     <= s_round;
							e_q     <= e_clip;
							state_q <= S_ADD_CALC;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_SPLIT_RD: begin
					b_q     <= head_q[ord_k(j_q)];
					state_q <= S_SPLIT_POP;
				end
				S_SPLIT_POP: state_q <= S_SPLIT_HI;
				S_SPLIT_HI:  state_q <= S_SPLIT_LO;
				S_SPLIT_LO: begin
					j_q     <= j_q - OW'(1);
					state_q <= (j_q - OW'(1) == ord_q) ? S_POP_RD : S_SPLIT_RD;
				end
				S_POP_RD: begin
					b_q     <= head_q[ord_k(ord_q)];
					state_q <= S_POP_WB;
				end
				S_POP_WB: begin
					res_addr_q <= {b_q, {MIN_ORDER{1'b0}}};
					alloc_q    <= alloc_q + (CW'(1) << ord_q);
					state_q    <= S_FIN;
				end
				S_MERGE_CHK: begin
					if (co_q < TOP_O) begin
						bud_q   <= bud_calc;
						p_q     <= head_q[ord_k(co_q)];
						steps_q <= '0;
						state_q <= S_SRCH_RD;
					end else begin
						state_q <= S_FREE_END;
					end
				end
				S_SRCH_RD: begin
					state_q <= steps_q[UW] ? S_FREE_END : S_SRCH_EV;
				end
				S_SRCH_EV: begin
					if (!rd_valid) begin
						state_q <= S_FREE_END;
					end else if (rd_next == bud_q) begin
						state_q <= S_UNLINK;
					end else begin
						p_q     <= rd_next;
						steps_q <= steps_q + (UW+1)'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_UNLINK:  state_q <= S_MPOP_RD;
				S_MPOP_RD: state_q <= S_MPOP_WB;
				S_MPOP_WB: begin
					if (bud_q < cur_q) cur_q <= bud_q;
					co_q    <= co_q + OW'(1);
					state_q <= S_MPUSH;
				end
				S_MPUSH: state_q <= S_MERGE_CHK;
				S_FREE_END: begin
					alloc_q <= alloc_q - (CW'(1) << ord_q);
					state_q <= S_FIN;
				end
				S_ADD_CALC: begin
					if (s_q < e_q) begin
						add_ord_q <= add_ord;
						state_q   <= S_ADD_PUSH;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_ADD_PUSH: begin
					total_q <= total_q + (CW'(1) << add_ord_q);
					s_q     <= s_q + (CW'(1) << add_ord_q);
					state_q <= S_ADD_CALC;
				end
				S_FIN: begin
					// hold until the output register is free
					if (!m_valid_q || m_tready) begin
						m_valid_q    <= 1'b1;
						out_status_q <= res_status_q;
						out_addr_q   <= res_addr_q;
						out_alloc_q  <= alloc_q;
						out_total_q  <= total_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{PADW{1'b0}}, out_total_q, out_alloc_q, out_addr_q, out_status_q};

endmodule
`default_nettype wire
